/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the gate netlist simulator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

/* hw/rtl/gns_pkg.sv */
// Package for the gate netlist simulator: field widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package gns_pkg;

  localparam int IDX_W         = 10;
  localparam int TYPE_W        = 3;
  localparam int LINK_W        = IDX_W + 1;
  localparam int TICK_W        = 32;
  localparam int DEF_MAX_GATES = 1024;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_CONNECT = 2'd1,
    ACT_TICK    = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  localparam logic [TYPE_W-1:0] GT_WIRE = 3'd0;
  localparam logic [TYPE_W-1:0] GT_AND  = 3'd1;
  localparam logic [TYPE_W-1:0] GT_OR   = 3'd2;
  localparam logic [TYPE_W-1:0] GT_NOT  = 3'd3;
  localparam logic [TYPE_W-1:0] GT_XOR  = 3'd4;
  localparam logic [TYPE_W-1:0] GT_NAND = 3'd5;
  localparam logic [TYPE_W-1:0] GT_NOR  = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CONN_WR,
    S_COPY,
    S_COPY_DRAIN,
    S_EVAL,
    S_EVAL_DRAIN,
    S_TICK_END,
    S_RESP
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic decode;
    logic add_wr;
    logic link_wr;
    logic idx_clr;
    logic idx_inc;
    logic copy_issue;
    logic eval_issue;
    logic tick_inc;
    logic emit;
  } gns_cmd_t;

  typedef struct packed {
    action_t action;
    logic    full;
    logic    tgt_ok;
    logic    src_ok;
    logic    gc_zero;
    logic    idx_last;
    logic    pipe_empty;
  } gns_stat_t;

endpackage

/* hw/rtl/gns_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gns_ram #(
  parameter int W = 1,
  parameter int D = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/gns_dp.sv */
// Datapath of the gate netlist simulator: item and result registers, gate count,
// tick counter, sweep index, netlist memories and the copy/evaluate pipelines.
// Depends on gns_pkg, gns_ram and assert_macros.svh.
`include "assert_macros.svh"
module gns_dp import gns_pkg::*; #(
  parameter int MAX_GATES = DEF_MAX_GATES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  gns_cmd_t          cmd_i,
  output gns_stat_t         stat_o,
  input  logic [1:0]        in_action,
  input  logic [IDX_W-1:0]  in_gate_index,
  input  logic [TYPE_W-1:0] in_gate_type,
  input  logic [IDX_W-1:0]  in_source_index,
  input  logic              in_input_port,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_assigned_index,
  output logic              out_out_value,
  output logic              out_next_value,
  output logic [TICK_W-1:0] out_tick_count
);

  localparam int AW   = $clog2(MAX_GATES);
  localparam int CW   = $clog2(MAX_GATES + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  action_t           act_r;
  logic [IDX_W-1:0]  tgt_r;
  logic [TYPE_W-1:0] type_r;
  logic [IDX_W-1:0]  src_r;
  logic              port_r;

  logic [CW-1:0]     gc_r;
  logic [TICK_W-1:0] ticks_r;
  logic [AW-1:0]     idx_r;

  logic              cv1_r;
  logic [AW-1:0]     ci1_r;
  logic              v1_r;
  logic [AW-1:0]     i1_r;
  logic              v2_r;
  logic [AW-1:0]     i2_r;
  logic [TYPE_W-1:0] k2_r;
  logic              xc2_r;
  logic              yc2_r;

  status_t           res_status_r;
  logic [IDX_W-1:0]  res_assigned_r;
  logic              out_valid_r;
  status_t           out_status_r;
  logic [IDX_W-1:0]  out_assigned_r;
  logic              out_value_r;
  logic              out_next_r;

  logic [TYPE_W-1:0] kind_rd;
  logic [LINK_W-1:0] xl_rd;
  logic [LINK_W-1:0] yl_rd;
  logic              cur_a_rd;
  logic              cur_b_rd;
  logic              pend_rd;

  logic [AW-1:0]     gc_addr;
  logic [AW-1:0]     tgt_addr;
  logic [AW-1:0]     kind_raddr;
  logic [AW-1:0]     cur_a_raddr;
  logic [AW-1:0]     cur_b_raddr;
  logic [AW-1:0]     pend_raddr;
  logic              to_x;
  logic              xl_we;
  logic              yl_we;
  logic [LINK_W-1:0] link_wdata;
  logic              cur_we;
  logic [AW-1:0]     cur_waddr;
  logic              cur_wdata;
  logic              pend_we;
  logic [AW-1:0]     pend_waddr;
  logic              pend_wdata;
  logic              gx;
  logic              gy;
  logic              gate_val;
  logic              full;
  logic              tgt_ok;
  logic              src_ok;
  status_t           dec_status;

  assign full     = (gc_r == CW'(MAX_GATES));
  assign tgt_ok   = (CMPW'(tgt_r) < CMPW'(gc_r));
  assign src_ok   = (CMPW'(src_r) < CMPW'(gc_r));
  assign gc_addr  = AW'(gc_r);
  assign tgt_addr = AW'(tgt_r);

  assign stat_o.action     = act_r;
  assign stat_o.full       = full;
  assign stat_o.tgt_ok     = tgt_ok;
  assign stat_o.src_ok     = src_ok;
  assign stat_o.gc_zero    = (gc_r == '0);
  assign stat_o.idx_last   = (CW'(idx_r) == gc_r - CW'(1));
  assign stat_o.pipe_empty = !(cv1_r || v1_r || v2_r);

  always_comb begin
    dec_status = ST_OK;
    if (act_r == ACT_ADD && full) begin
      dec_status = ST_FULL;
    end else if ((act_r == ACT_CONNECT && !(tgt_ok && src_ok)) ||
                 (act_r == ACT_READ && !tgt_ok)) begin
      dec_status = ST_BADIDX;
    end
  end

  // read address selection
  assign kind_raddr  = cmd_i.eval_issue ? idx_r : tgt_addr;
  assign cur_a_raddr = v1_r ? AW'(xl_rd[LINK_W-1:1]) : tgt_addr;
  assign cur_b_raddr = AW'(yl_rd[LINK_W-1:1]);
  assign pend_raddr  = cmd_i.copy_issue ? idx_r : tgt_addr;

  // write port selection
  assign to_x       = (kind_rd == GT_WIRE) || (kind_rd == GT_NOT) || port_r;
  assign xl_we      = cmd_i.add_wr || (cmd_i.link_wr && to_x);
  assign yl_we      = cmd_i.add_wr || (cmd_i.link_wr && !to_x);
  assign link_wdata = cmd_i.add_wr ? '0 : {src_r, 1'b1};
  assign cur_we     = cmd_i.add_wr || cv1_r;
  assign cur_waddr  = cmd_i.add_wr ? gc_addr : ci1_r;
  assign cur_wdata  = cmd_i.add_wr ? 1'b0 : pend_rd;
  assign pend_we    = cmd_i.add_wr || v2_r;
  assign pend_waddr = cmd_i.add_wr ? gc_addr : i2_r;
  assign pend_wdata = cmd_i.add_wr ? 1'b0 : gate_val;

  assign gx = xc2_r & cur_a_rd;
  assign gy = yc2_r & cur_b_rd;

  always_comb begin
    unique case (k2_r)
      GT_WIRE: gate_val = gx;
      GT_AND:  gate_val = gx & gy;
      GT_OR:   gate_val = gx | gy;
      GT_NOT:  gate_val = ~gx;
      GT_XOR:  gate_val = gx ^ gy;
      GT_NAND: gate_val = ~(gx & gy);
      GT_NOR:  gate_val = ~(gx | gy);
      default: gate_val = 1'b0;
    endcase
  end

  gns_ram #(.W(TYPE_W), .D(MAX_GATES)) u_kind (
    .clk(clk), .we(cmd_i.add_wr), .waddr(gc_addr), .wdata(type_r),
    .raddr(kind_raddr), .rdata(kind_rd)
  );

  gns_ram #(.W(LINK_W), .D(MAX_GATES)) u_xlink (
    .clk(clk), .we(xl_we), .waddr(cmd_i.add_wr ? gc_addr : tgt_addr), .wdata(link_wdata),
    .raddr(idx_r), .rdata(xl_rd)
  );

  gns_ram #(.W(LINK_W), .D(MAX_GATES)) u_ylink (
    .clk(clk), .we(yl_we), .waddr(cmd_i.add_wr ? gc_addr : tgt_addr), .wdata(link_wdata),
    .raddr(idx_r), .rdata(yl_rd)
  );

  gns_ram #(.W(1), .D(MAX_GATES)) u_cur_a (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_a_raddr), .rdata(cur_a_rd)
  );

  gns_ram #(.W(1), .D(MAX_GATES)) u_cur_b (
    .clk(clk), .we(cur_we), .waddr(cur_waddr), .wdata(cur_wdata),
    .raddr(cur_b_raddr), .rdata(cur_b_rd)
  );

  gns_ram #(.W(1), .D(MAX_GATES)) u_pend (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gc_r        <= '0;
      ticks_r     <= '0;
      cv1_r       <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.add_wr) begin
        gc_r <= gc_r + CW'(1);
      end
      if (cmd_i.tick_inc) begin
        ticks_r <= ticks_r + TICK_W'(1);
      end
      cv1_r       <= cmd_i.copy_issue;
      v1_r        <= cmd_i.eval_issue;
      v2_r        <= v1_r;
      out_valid_r <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      act_r  <= action_t'(in_action);
      tgt_r  <= in_gate_index;
      type_r <= in_gate_type;
      src_r  <= in_source_index;
      port_r <= in_input_port;
    end
    if (cmd_i.idx_clr) begin
      idx_r <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_r <= idx_r + AW'(1);
    end
    ci1_r <= idx_r;
    i1_r  <= idx_r;
    i2_r  <= i1_r;
    k2_r  <= kind_rd;
    xc2_r <= xl_rd[0];
    yc2_r <= yl_rd[0];
    if (cmd_i.decode) begin
      res_status_r   <= dec_status;
      res_assigned_r <= (act_r == ACT_ADD && !full) ? IDX_W'(gc_r) : '0;
    end
    if (cmd_i.emit) begin
      out_status_r   <= res_status_r;
      out_assigned_r <= res_assigned_r;
      out_value_r    <= (act_r == ACT_READ && res_status_r == ST_OK) ? cur_a_rd : 1'b0;
      out_next_r     <= (act_r == ACT_READ && res_status_r == ST_OK) ? pend_rd : 1'b0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_assigned_index = out_assigned_r;
  assign out_out_value      = out_value_r;
  assign out_next_value     = out_next_r;
  assign out_tick_count     = ticks_r;

  `ASSERT_CLK(a_gc_bound, clk, rst_n, (CMPW'(gc_r) <= CMPW'(MAX_GATES)), "gate count overflow")
  `ASSERT_NEVER(a_wport, clk, rst_n, cmd_i.add_wr && (cv1_r || v2_r), "write port clash")
  `ASSERT_CLK(a_tick, clk, rst_n, cmd_i.tick_inc |=> ticks_r == $past(ticks_r) + TICK_W'(1), "tick count")

endmodule

/* hw/rtl/gns_ctrl.sv */
// Controller of the gate netlist simulator: item sequencing and the two tick sweeps.
// Depends on gns_pkg and assert_macros.svh.
`include "assert_macros.svh"
module gns_ctrl import gns_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  gns_stat_t stat_i,
  output gns_cmd_t  cmd_o
);

  ctrl_state_t st_r;
  ctrl_state_t st_nxt;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: begin
        if (start) st_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (stat_i.action)
          ACT_ADD:     st_nxt = S_RESP;
          ACT_CONNECT: st_nxt = (stat_i.tgt_ok && stat_i.src_ok) ? S_CONN_WR : S_RESP;
          ACT_TICK:    st_nxt = stat_i.gc_zero ? S_TICK_END : S_COPY;
          ACT_READ:    st_nxt = S_RESP;
          default:     st_nxt = S_RESP;
        endcase
      end
      S_CONN_WR: st_nxt = S_RESP;
      S_COPY: begin
        if (stat_i.idx_last) st_nxt = S_COPY_DRAIN;
      end
      S_COPY_DRAIN: begin
        if (stat_i.pipe_empty) st_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.idx_last) st_nxt = S_EVAL_DRAIN;
      end
      S_EVAL_DRAIN: begin
        if (stat_i.pipe_empty) st_nxt = S_TICK_END;
      end
      S_TICK_END: st_nxt = S_RESP;
      S_RESP:     st_nxt = S_IDLE;
      default:    st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (st_r)
      S_IDLE: cmd_o.load = start;
      S_DECODE: begin
        cmd_o.decode  = 1'b1;
        cmd_o.add_wr  = (stat_i.action == ACT_ADD) && !stat_i.full;
        cmd_o.idx_clr = 1'b1;
      end
      S_CONN_WR: cmd_o.link_wr = 1'b1;
      S_COPY: begin
        cmd_o.copy_issue = 1'b1;
        cmd_o.idx_inc    = 1'b1;
      end
      S_COPY_DRAIN: cmd_o.idx_clr = 1'b1;
      S_EVAL: begin
        cmd_o.eval_issue = 1'b1;
        cmd_o.idx_inc    = 1'b1;
      end
      S_EVAL_DRAIN: cmd_o.idx_clr = 1'b0;
      S_TICK_END:   cmd_o.tick_inc = 1'b1;
      S_RESP:       cmd_o.emit = 1'b1;
      default:      cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);

  `ASSERT_CLK(a_accept, clk, rst_n, (st_r == S_IDLE && start) |=> st_r == S_DECODE, "accept")
  `ASSERT_CLK(a_emit, clk, rst_n, cmd_o.emit |=> st_r == S_IDLE, "result not last")
  `ASSERT_CLK(a_drain, clk, rst_n, (st_r == S_EVAL_DRAIN && stat_i.pipe_empty) |=> st_r == S_TICK_END, "drain")

endmodule

/* hw/rtl/gate_netlist_simulator.sv */
// Gate netlist simulator top level: controller plus datapath.
// Depends on gns_pkg, gns_ctrl, gns_dp (and gns_ram below it).
//
// Items are taken when start is high and busy is low; each item gives exactly one
// result, shown for one cycle with out_valid high, which the receiver cannot stall.
// Add, read and rejected items pass from accept through the decode and result states;
// connect items also pass the link-write state. In a tick, one sweep copies next
// values into current values (one gate per cycle through the next-value RAM), then
// a three-stage pipeline reads each gate's type and links, reads both source values
// and writes the new next value, one gate per cycle. No clearing pass after reset.
module gate_netlist_simulator import gns_pkg::*; #(
  parameter int MAX_GATES = DEF_MAX_GATES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [IDX_W-1:0]  in_gate_index,
  input  logic [TYPE_W-1:0] in_gate_type,
  input  logic [IDX_W-1:0]  in_source_index,
  input  logic              in_input_port,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [IDX_W-1:0]  out_assigned_index,
  output logic              out_out_value,
  output logic              out_next_value,
  output logic [TICK_W-1:0] out_tick_count
);

  gns_cmd_t  cmd;
  gns_stat_t stat;

  gns_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  gns_dp #(.MAX_GATES(MAX_GATES)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .in_action          (in_action),
    .in_gate_index      (in_gate_index),
    .in_gate_type       (in_gate_type),
    .in_source_index    (in_source_index),
    .in_input_port      (in_input_port),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_assigned_index (out_assigned_index),
    .out_out_value      (out_out_value),
    .out_next_value     (out_next_value),
    .out_tick_count     (out_tick_count)
  );

endmodule
